### rtl/smtl_pkg.sv
// Shared types and constants for the sector mapping translation layer.
// Used by the top level, front end and back end; depends on nothing.
package smtl_pkg;

    localparam int SECTORS = 2048;
    localparam int SECTORS_PER_BLOCK = 32;
    localparam int SECT_W = 11;
    localparam int DATA_W = 32;
    localparam int BLK_W = 6;
    localparam int CNT_W = 32;
    localparam int OFS_W = $clog2(SECTORS_PER_BLOCK);

    typedef enum logic [1:0] {
        FUNC_READ   = 2'd0,
        FUNC_WRITE  = 2'd1,
        FUNC_ERASE  = 2'd2,
        FUNC_REPORT = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NO_FREE = 2'd1,
        STAT_RANGE   = 2'd2
    } status_t;

    // Classified request handed from front to back
    typedef struct packed {
        func_t              func;
        logic               bad_addr;
        logic [SECT_W-1:0]  lsn;
        logic [DATA_W-1:0]  data;
        logic [BLK_W-1:0]   blk;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_CHECK,
        ST_SCAN,
        ST_SWAP1,
        ST_SWAP2,
        ST_ERASE,
        ST_FINISH
    } state_t;

endpackage

### rtl/sector_mapping_translation_layer.sv
// Top level of the sector mapping translation layer: stream ports, front and back end.
// Depends on smtl_pkg, smtl_front, smtl_back (and smtl_ram through the back end).
//
// After reset the block initializes the map to identity and the store to empty;
// requests are queued but not executed during that time. An erase clears its block
// one sector a cycle on the store's write port, and a write to an occupied sector
// runs the lowest-empty-sector search, which covers every sector when none is
// empty. A two-entry request queue and a result register let the host side run
// ahead of execution.
module sector_mapping_translation_layer (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [55:0]  s_tdata,   // logical_sector[10:0], write_data[42:11], erase_block[48:43]
    input  logic [1:0]   s_tuser,   // func[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata    // phys_sector[10:0], read_data[42:11], status[44:43],
                                    // reads_done[76:45], writes_done[108:77], erases_done[140:109]
);

    logic           q_valid, q_pop;
    smtl_pkg::cmd_t q_cmd;
    logic [10:0]    phys;
    logic [31:0]    rdata, reads, writes, erases;
    logic [1:0]     status;

    smtl_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_tvalid), .s_ready(s_tready),
        .s_func(smtl_pkg::func_t'(s_tuser)),
        .s_lsn(s_tdata[10:0]), .s_data(s_tdata[42:11]), .s_blk(s_tdata[48:43]),
        .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
    );

    smtl_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_phys(phys), .out_rdata(rdata), .out_status(status),
        .out_reads(reads), .out_writes(writes), .out_erases(erases)
    );

    assign m_tdata = {3'b000, erases, writes, reads, status, rdata, phys};

endmodule

### rtl/smtl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smtl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/smtl_front.sv
// Front end: accepts requests, checks address range, queues them for the back end.
// Depends on smtl_pkg.
module smtl_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  smtl_pkg::func_t         s_func,
    input  logic [smtl_pkg::SECT_W-1:0] s_lsn,
    input  logic [smtl_pkg::DATA_W-1:0] s_data,
    input  logic [smtl_pkg::BLK_W-1:0]  s_blk,
    output logic                    q_valid,
    output smtl_pkg::cmd_t          q_cmd,
    input  logic                    q_pop
);

    smtl_pkg::cmd_t entry_reg [2];
    smtl_pkg::cmd_t cmd_in;
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           push;
    logic           bad_lsn, bad_blk;

    // Range checks
    assign bad_lsn = ({1'b0, s_lsn} >= (smtl_pkg::SECT_W+1)'(smtl_pkg::SECTORS));
    assign bad_blk = ({1'b0, s_blk, {smtl_pkg::OFS_W{1'b0}}}
                      >= (smtl_pkg::BLK_W+smtl_pkg::OFS_W+1)'(smtl_pkg::SECTORS));

    always_comb begin
        cmd_in.func = s_func;
        cmd_in.lsn  = s_lsn;
        cmd_in.data = s_data;
        cmd_in.blk  = s_blk;
        case (s_func)
            smtl_pkg::FUNC_READ, smtl_pkg::FUNC_WRITE: cmd_in.bad_addr = bad_lsn;
            smtl_pkg::FUNC_ERASE:                      cmd_in.bad_addr = bad_blk;
            default:                                   cmd_in.bad_addr = 1'b0;
        endcase
    end

    // Two-entry queue
    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

### rtl/smtl_back.sv
// Back end: executes queued requests against the map, inverse map and sector store.
// Depends on smtl_pkg and smtl_ram.
module smtl_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_valid,
    input  smtl_pkg::cmd_t               q_cmd,
    output logic                         q_pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [smtl_pkg::SECT_W-1:0]  out_phys,
    output logic [smtl_pkg::DATA_W-1:0]  out_rdata,
    output logic [1:0]                   out_status,
    output logic [smtl_pkg::CNT_W-1:0]   out_reads,
    output logic [smtl_pkg::CNT_W-1:0]   out_writes,
    output logic [smtl_pkg::CNT_W-1:0]   out_erases
);

    localparam int SW = smtl_pkg::SECT_W;
    localparam int DW = smtl_pkg::DATA_W;
    localparam int CW = smtl_pkg::CNT_W;
    localparam int OW = smtl_pkg::OFS_W;
    localparam logic [SW-1:0] LAST = SW'(smtl_pkg::SECTORS - 1);

    smtl_pkg::state_t state_reg, state_next;
    smtl_pkg::cmd_t   cmd_reg, cmd_next;
    logic [SW-1:0]    used_reg, used_next;
    logic [SW-1:0]    idx_reg, idx_next;
    logic [SW-1:0]    l2_reg, l2_next;
    logic [OW-1:0]    ofs_reg, ofs_next;
    logic [SW-1:0]    phys_reg, phys_next;
    logic [DW-1:0]    rdata_reg, rdata_next;
    logic [1:0]       status_reg, status_next;
    logic [CW-1:0]    reads_reg, writes_reg, erases_reg;
    logic [1:0]       rd_inc;
    logic             wr_inc, er_inc, cnt_clr, out_load;
    logic             out_valid_reg;
    logic [SW-1:0]    o_phys_reg;
    logic [DW-1:0]    o_rdata_reg;
    logic [1:0]       o_status_reg;
    logic [CW-1:0]    o_reads_reg, o_writes_reg, o_erases_reg;

    // Memory ports
    logic          map_we, inv_we, st_we;
    logic [SW-1:0] map_waddr, map_wdata, map_raddr, map_rd;
    logic [SW-1:0] inv_waddr, inv_wdata, inv_raddr, inv_rd;
    logic [SW-1:0] st_waddr, st_raddr;
    logic [DW-1:0] st_wdata, st_rd;
    logic          out_free, is_zero;

    assign out_free = !out_valid_reg || out_ready;
    assign is_zero  = (st_rd == '0);

    smtl_ram #(.WIDTH(SW), .DEPTH(smtl_pkg::SECTORS)) u_map (
        .aclk(aclk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
        .raddr(map_raddr), .rdata(map_rd)
    );

    smtl_ram #(.WIDTH(SW), .DEPTH(smtl_pkg::SECTORS)) u_inv (
        .aclk(aclk), .we(inv_we), .waddr(inv_waddr), .wdata(inv_wdata),
        .raddr(inv_raddr), .rdata(inv_rd)
    );

    smtl_ram #(.WIDTH(DW), .DEPTH(smtl_pkg::SECTORS)) u_store (
        .aclk(aclk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(st_raddr), .rdata(st_rd)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            smtl_pkg::ST_CLEAR: begin
                if (idx_reg == LAST) state_next = smtl_pkg::ST_IDLE;
            end
            smtl_pkg::ST_IDLE: begin
                if (q_valid) begin
                    if (q_cmd.bad_addr) begin
                        state_next = smtl_pkg::ST_FINISH;
                    end else begin
                        unique case (q_cmd.func)
                            smtl_pkg::FUNC_READ,
                            smtl_pkg::FUNC_WRITE: state_next = smtl_pkg::ST_LOOKUP;
                            smtl_pkg::FUNC_ERASE: state_next = smtl_pkg::ST_ERASE;
                            default:              state_next = smtl_pkg::ST_FINISH;
                        endcase
                    end
                end
            end
            smtl_pkg::ST_LOOKUP: state_next = smtl_pkg::ST_CHECK;
            smtl_pkg::ST_CHECK: begin
                if (cmd_reg.func == smtl_pkg::FUNC_WRITE && !is_zero) begin
                    state_next = smtl_pkg::ST_SCAN;
                end else begin
                    state_next = smtl_pkg::ST_FINISH;
                end
            end
            smtl_pkg::ST_SCAN: begin
                if (is_zero)              state_next = smtl_pkg::ST_SWAP1;
                else if (idx_reg == LAST) state_next = smtl_pkg::ST_FINISH;
            end
            smtl_pkg::ST_SWAP1: state_next = smtl_pkg::ST_SWAP2;
            smtl_pkg::ST_SWAP2: state_next = smtl_pkg::ST_FINISH;
            smtl_pkg::ST_ERASE: begin
                if (ofs_reg == {OW{1'b1}}) state_next = smtl_pkg::ST_FINISH;
            end
            smtl_pkg::ST_FINISH: begin
                if (out_free) state_next = smtl_pkg::ST_IDLE;
            end
            default: state_next = smtl_pkg::ST_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        cmd_next    = cmd_reg;
        used_next   = used_reg;
        idx_next    = idx_reg;
        l2_next     = l2_reg;
        ofs_next    = ofs_reg;
        phys_next   = phys_reg;
        rdata_next  = rdata_reg;
        status_next = status_reg;
        rd_inc      = 2'd0;
        wr_inc      = 1'b0;
        er_inc      = 1'b0;
        cnt_clr     = 1'b0;
        out_load    = 1'b0;
        q_pop       = 1'b0;
        map_we      = 1'b0;
        map_waddr   = idx_reg;
        map_wdata   = idx_reg;
        map_raddr   = q_cmd.lsn;
        inv_we      = 1'b0;
        inv_waddr   = idx_reg;
        inv_wdata   = idx_reg;
        inv_raddr   = idx_reg;
        st_we       = 1'b0;
        st_waddr    = idx_reg;
        st_wdata    = '0;
        st_raddr    = map_rd;
        unique case (state_reg)
            smtl_pkg::ST_CLEAR: begin
                // Identity map, empty store, one entry a cycle
                map_we   = 1'b1;
                inv_we   = 1'b1;
                st_we    = 1'b1;
                idx_next = idx_reg + SW'(1);
            end
            smtl_pkg::ST_IDLE: begin
                if (q_valid) begin
                    q_pop       = 1'b1;
                    cmd_next    = q_cmd;
                    phys_next   = '0;
                    rdata_next  = '0;
                    ofs_next    = '0;
                    status_next = q_cmd.bad_addr ? smtl_pkg::STAT_RANGE : smtl_pkg::STAT_OK;
                    er_inc      = (q_cmd.func == smtl_pkg::FUNC_ERASE) && !q_cmd.bad_addr;
                end
            end
            smtl_pkg::ST_LOOKUP: begin
                used_next = map_rd;
            end
            smtl_pkg::ST_CHECK: begin
                if (cmd_reg.func == smtl_pkg::FUNC_READ) begin
                    rd_inc     = 2'd1;
                    phys_next  = used_reg;
                    rdata_next = st_rd;
                end else if (is_zero) begin
                    // In-place write
                    rd_inc    = 2'd2;
                    wr_inc    = 1'b1;
                    st_we     = 1'b1;
                    st_waddr  = used_reg;
                    st_wdata  = cmd_reg.data;
                    phys_next = used_reg;
                end else begin
                    rd_inc   = 2'd1;
                    idx_next = '0;
                    st_raddr = '0;
                end
            end
            smtl_pkg::ST_SCAN: begin
                // Lowest empty sector search
                rd_inc = 2'd1;
                if (is_zero) begin
                    inv_raddr = idx_reg;
                end else if (idx_reg == LAST) begin
                    status_next = smtl_pkg::STAT_NO_FREE;
                end else begin
                    idx_next = idx_reg + SW'(1);
                    st_raddr = idx_reg + SW'(1);
                end
            end
            smtl_pkg::ST_SWAP1: begin
                rd_inc    = 2'd1;
                wr_inc    = 1'b1;
                st_we     = 1'b1;
                st_waddr  = idx_reg;
                st_wdata  = cmd_reg.data;
                map_we    = 1'b1;
                map_waddr = cmd_reg.lsn;
                map_wdata = idx_reg;
                inv_we    = 1'b1;
                inv_waddr = idx_reg;
                inv_wdata = cmd_reg.lsn;
                l2_next   = inv_rd;
                phys_next = idx_reg;
            end
            smtl_pkg::ST_SWAP2: begin
                map_we    = 1'b1;
                map_waddr = l2_reg;
                map_wdata = used_reg;
                inv_we    = 1'b1;
                inv_waddr = used_reg;
                inv_wdata = l2_reg;
            end
            smtl_pkg::ST_ERASE: begin
                st_we    = 1'b1;
                st_waddr = SW'({cmd_reg.blk, ofs_reg});
                ofs_next = ofs_reg + OW'(1);
            end
            smtl_pkg::ST_FINISH: begin
                if (out_free) begin
                    out_load = 1'b1;
                    cnt_clr  = (cmd_reg.func == smtl_pkg::FUNC_REPORT);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= smtl_pkg::ST_CLEAR;
            idx_reg       <= '0;
            reads_reg     <= '0;
            writes_reg    <= '0;
            erases_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (cnt_clr) begin
                reads_reg  <= '0;
                writes_reg <= '0;
                erases_reg <= '0;
            end else begin
                reads_reg  <= reads_reg + CW'(rd_inc);
                writes_reg <= writes_reg + CW'(wr_inc);
                erases_reg <= erases_reg + CW'(er_inc);
            end
            if (out_load)       out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        used_reg   <= used_next;
        l2_reg     <= l2_next;
        ofs_reg    <= ofs_next;
        phys_reg   <= phys_next;
        rdata_reg  <= rdata_next;
        status_reg <= status_next;
        if (out_load) begin
            o_phys_reg   <= phys_reg;
            o_rdata_reg  <= rdata_reg;
            o_status_reg <= status_reg;
            o_reads_reg  <= reads_reg;
            o_writes_reg <= writes_reg;
            o_erases_reg <= erases_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_phys   = o_phys_reg;
    assign out_rdata  = o_rdata_reg;
    assign out_status = o_status_reg;
    assign out_reads  = o_reads_reg;
    assign out_writes = o_writes_reg;
    assign out_erases = o_erases_reg;

`ifndef SYNTHESIS
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (state_reg == smtl_pkg::ST_IDLE))
        else $error("queue popped outside idle");
    a_swap_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == smtl_pkg::ST_SWAP1) |-> ($past(state_reg) == smtl_pkg::ST_SCAN))
        else $error("swap entered without scan");
    a_inplace_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == smtl_pkg::ST_CHECK && st_we) |-> is_zero)
        else $error("in-place write to occupied sector");
    a_load_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> out_valid_reg)
        else $error("result lost");
`endif

endmodule
